// File: sv/lfb_pkg.sv
// Package with the shared types, codes and helper functions of the LIN frame builder.
package lfb_pkg;

  // Input function codes.
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_HEADER = 2'd2;

  // Command codes between the front and the back end.
  localparam logic CMD_HDR  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Result kinds.
  localparam logic KIND_BREAK = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // Fixed protocol values.
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [4:0] MIN_BREAK = 5'd13;

  // One queued command: everything the back end needs to emit its results.
  typedef struct packed {
    logic       op;          // CMD_HDR or CMD_DATA
    logic [7:0] byte_val;    // protected identifier or data byte
    logic [7:0] cksum;       // inverted checksum to send after the byte
    logic       with_cksum;  // a checksum follows
    logic       hdr_end;     // the protected identifier closes a header-only request
    logic [4:0] blen;        // break length in bit times
  } cmd_t;

  // Protected identifier: P0 in bit 6, inverted P1 in bit 7.
  function automatic logic [7:0] prot_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Eight-bit addition with end-around carry.
  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? (s[7:0] + 8'd1) : s[7:0];
  endfunction

endpackage

// File: sv/lfb_front.sv
// Front end: accepts and classifies input items, keeps the checksum state and queues commands.
module lfb_front
  import lfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Input items.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [5:0] frame_id,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  // Configuration register write.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  // Command queue write side.
  output logic       push,
  output cmd_t       cmd,
  input  logic       full
);

  logic [4:0] break_bits;
  logic [7:0] running_sum;
  logic       frame_open;
  logic [7:0] running_sum_next;
  logic       frame_open_next;
  logic [7:0] pid;
  logic [7:0] sum_data;
  logic       accept;
  logic       emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  assign pid      = prot_id(frame_id);
  assign sum_data = add_carry(running_sum, data_byte);

  // Classify the item and build the command it causes.
  always_comb begin
    emit             = 1'b0;
    running_sum_next = running_sum;
    frame_open_next  = frame_open;
    cmd.op           = CMD_HDR;
    cmd.byte_val     = pid;
    cmd.cksum        = ~pid;
    cmd.with_cksum   = 1'b0;
    cmd.hdr_end      = 1'b0;
    cmd.blen         = (break_bits < MIN_BREAK) ? MIN_BREAK : break_bits;
    case (func)
      FUNC_START: begin
        emit           = 1'b1;
        cmd.with_cksum = is_last;
        if (is_last) begin
          running_sum_next = 8'd0;
          frame_open_next  = 1'b0;
        end else begin
          running_sum_next = pid;
          frame_open_next  = 1'b1;
        end
      end
      FUNC_DATA: begin
        emit           = frame_open;
        cmd.op         = CMD_DATA;
        cmd.byte_val   = data_byte;
        cmd.cksum      = ~sum_data;
        cmd.with_cksum = is_last;
        if (frame_open) begin
          if (is_last) begin
            running_sum_next = 8'd0;
            frame_open_next  = 1'b0;
          end else begin
            running_sum_next = sum_data;
          end
        end
      end
      FUNC_HEADER: begin
        emit             = 1'b1;
        cmd.hdr_end      = 1'b1;
        running_sum_next = 8'd0;
        frame_open_next  = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push = accept && emit;

  // Frame state and the break length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      break_bits  <= MIN_BREAK;
      running_sum <= 8'd0;
      frame_open  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        break_bits <= cfg_data;
      end
      if (accept) begin
        running_sum <= running_sum_next;
        frame_open  <= frame_open_next;
      end
    end
  end

endmodule

// File: sv/lfb_queue.sv
// Short command queue that decouples the front end from the back end.
module lfb_queue
  import lfb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/lfb_back.sv
// Back end: turns each queued command into registered result items, one per cycle unless stalled.
module lfb_back
  import lfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Command queue read side.
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  // Result items.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [4:0] break_len,
  output logic       frame_end
);

  logic [1:0] step;
  logic       advance;
  logic       last_step;
  logic       r_kind;
  logic [7:0] r_byte;
  logic [4:0] r_blen;
  logic       r_end;

  assign advance = !empty && (!out_valid || out_ready);
  assign pop     = advance && last_step;

  // Select the result for the current step of the head command.
  always_comb begin
    r_kind    = KIND_BYTE;
    r_byte    = head.cksum;
    r_blen    = 5'd0;
    r_end     = 1'b1;
    last_step = 1'b1;
    if (head.op == CMD_HDR) begin
      case (step)
        2'd0: begin
          r_kind    = KIND_BREAK;
          r_byte    = 8'd0;
          r_blen    = head.blen;
          r_end     = 1'b0;
          last_step = 1'b0;
        end
        2'd1: begin
          r_byte    = SYNC_BYTE;
          r_end     = 1'b0;
          last_step = 1'b0;
        end
        2'd2: begin
          r_byte    = head.byte_val;
          r_end     = head.hdr_end;
          last_step = !head.with_cksum;
        end
        default: begin
          last_step = 1'b1;
        end
      endcase
    end else begin
      if (step == 2'd0) begin
        r_byte    = head.byte_val;
        r_end     = 1'b0;
        last_step = !head.with_cksum;
      end
    end
  end

  // Step counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        step      <= last_step ? 2'd0 : step + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      kind      <= r_kind;
      out_byte  <= r_byte;
      break_len <= r_blen;
      frame_end <= r_end;
    end
  end

endmodule

// File: sv/lin_frame_builder_unit.sv
// Top level of the LIN frame builder: front end, command queue and back end.
//
//  Channel | Direction | Handshake          | Payload
//  s_*     | in        | s_tvalid/s_tready  | tdata: frame_id, data_byte; tuser: func; tlast: is_last
//  m_*     | out       | m_tvalid/m_tready  | tdata: out_byte, break_len; tuser: kind; tlast: frame_end
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_data: break_bits
//
// The front end takes one item per cycle while the command queue has room.
// The back end emits one result per cycle unless the output stalls: a start item gives
// three or four results, a data item one or two, so the output sequencer sets the rate.
// Reset clears the queue, the frame state and the break length (to 13).
// A stalled output holds its register; the queue absorbs up to DEPTH commands.
module lin_frame_builder_unit
  import lfb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] frame_id, [13:6] data_byte, [15:14] zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [12:8] break_len, [15:13] zero
  output logic [0:0]  m_tuser,   // [0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  cmd_t       push_cmd;
  cmd_t       head;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  logic       kind;
  logic [7:0] out_byte;
  logic [4:0] break_len;

  // Classification and frame state.
  lfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tuser),
    .frame_id  (s_tdata[5:0]),
    .data_byte (s_tdata[13:6]),
    .is_last   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .cmd       (push_cmd),
    .full      (full)
  );

  // Command queue.
  lfb_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Result sequencer.
  lfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .kind      (kind),
    .out_byte  (out_byte),
    .break_len (break_len),
    .frame_end (m_tlast)
  );

  // Output packing.
  assign m_tdata = {3'b000, break_len, out_byte};
  assign m_tuser = kind;

endmodule

// File: tb/tb_lin_frame_builder_unit.sv
// Self-checking testbench for the LIN frame builder: stimulus, prediction and result checks.
`timescale 1ns / 1ps

// One input transaction as the block sees it.
typedef struct packed {
  logic [1:0] func;
  logic [5:0] frame_id;
  logic [7:0] data_byte;
  logic       is_last;
} lin_item_t;

// One output transaction of the byte stream.
typedef struct packed {
  logic       kind;
  logic [7:0] out_byte;
  logic [4:0] break_len;
  logic       frame_end;
} lin_symbol_t;

// Predicts the byte stream of each accepted item and checks the stream that comes out.
class lin_stream_checker;
  lin_symbol_t expected_symbols[$];
  logic [4:0]  break_setting;
  logic [7:0]  checksum_acc;
  bit          frame_busy;
  int          mismatches;
  int          symbols_seen;
  int          frames_closed;
  int          live_items;
  int          ignored_items;

  function new();
    break_setting = lfb_pkg::MIN_BREAK;
    checksum_acc  = 8'h00;
    frame_busy    = 1'b0;
    mismatches    = 0;
    symbols_seen  = 0;
    frames_closed = 0;
    live_items    = 0;
    ignored_items = 0;
  endfunction

  // Identifier with P0 in bit 6 and inverted P1 in bit 7.
  function logic [7:0] protect_id(logic [5:0] id);
    logic p0;
    logic p1;
    p0 = ^{id[0], id[1], id[2], id[4]};
    p1 = ~^{id[1], id[3], id[4], id[5]};
    return {p1, p0, id};
  endfunction

  // Eight-bit sum where a carry out wraps back into bit 0.
  function logic [7:0] sum_with_carry(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

  function void push_symbol(logic kind, logic [7:0] value, logic [4:0] blen, logic fend);
    lin_symbol_t sym;
    sym.kind      = kind;
    sym.out_byte  = value;
    sym.break_len = blen;
    sym.frame_end = fend;
    expected_symbols.push_back(sym);
  endfunction

  // Break, sync and protected identifier; a short break setting is raised to the minimum.
  function void push_header(logic [7:0] pid, logic fend);
    logic [4:0] blen;
    blen = (break_setting < lfb_pkg::MIN_BREAK) ? lfb_pkg::MIN_BREAK : break_setting;
    push_symbol(lfb_pkg::KIND_BREAK, 8'h00, blen, 1'b0);
    push_symbol(lfb_pkg::KIND_BYTE, lfb_pkg::SYNC_BYTE, 5'd0, 1'b0);
    push_symbol(lfb_pkg::KIND_BYTE, pid, 5'd0, fend);
  endfunction

  // Called once per accepted input transaction.
  function void note_item(lin_item_t it);
    logic [7:0] pid;
    pid = protect_id(it.frame_id);
    case (it.func)
      lfb_pkg::FUNC_START: begin
        live_items++;
        push_header(pid, 1'b0);
        checksum_acc = pid;
        if (it.is_last) begin
          // A start with no payload closes at once with the checksum of the identifier.
          push_symbol(lfb_pkg::KIND_BYTE, ~checksum_acc, 5'd0, 1'b1);
          frame_busy   = 1'b0;
          checksum_acc = 8'h00;
        end else begin
          frame_busy = 1'b1;
        end
      end
      lfb_pkg::FUNC_DATA: begin
        if (!frame_busy) begin
          ignored_items++;
        end else begin
          live_items++;
          checksum_acc = sum_with_carry(checksum_acc, it.data_byte);
          push_symbol(lfb_pkg::KIND_BYTE, it.data_byte, 5'd0, 1'b0);
          if (it.is_last) begin
            push_symbol(lfb_pkg::KIND_BYTE, ~checksum_acc, 5'd0, 1'b1);
            frame_busy   = 1'b0;
            checksum_acc = 8'h00;
          end
        end
      end
      lfb_pkg::FUNC_HEADER: begin
        live_items++;
        frame_busy   = 1'b0;
        checksum_acc = 8'h00;
        push_header(pid, 1'b1);
      end
      default: begin
        ignored_items++;
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", symbols_seen, msg);
    mismatches++;
  endtask

  // Called once per accepted output transaction.
  task check_result(logic kind, logic [7:0] value, logic [4:0] blen, logic fend);
    lin_symbol_t want;
    symbols_seen++;
    if (fend) begin
      frames_closed++;
    end
    if (expected_symbols.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h", kind, value));
    end else begin
      want = expected_symbols.pop_front();
      if (kind !== want.kind) begin
        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
      end
      if (value !== want.out_byte) begin
        report_mismatch($sformatf("out_byte %02h, want %02h", value, want.out_byte));
      end
      if (blen !== want.break_len) begin
        report_mismatch($sformatf("break_len %0d, want %0d", blen, want.break_len));
      end
      if (fend !== want.frame_end) begin
        report_mismatch($sformatf("frame_end %0d, want %0d", fend, want.frame_end));
      end
    end
  endtask
endclass

module tb_lin_frame_builder_unit;
  import lfb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_GAP   = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LIMIT   = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  logic [1:0]  s_tuser = 2'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = 5'd0;

  lin_stream_checker tracker;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int settings_used = 0;

  lin_frame_builder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output monitor: every accepted output transaction is checked in order.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_result(m_tuser[0], m_tdata[7:0], m_tdata[12:8], m_tlast);
    end
  end

  // Offer one item, idling first at the sender's rate, and wait for its transaction.
  task automatic send_item(input lin_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {2'b00, it.data_byte, it.frame_id};
    s_tlast  <= it.is_last;
    do @(posedge clk); while (!s_tready);
    tracker.note_item(it);
  endtask

  task automatic send_fields(input logic [1:0] func, input logic [5:0] id,
                             input logic [7:0] value, input logic last);
    lin_item_t it;
    it.func      = func;
    it.frame_id  = id;
    it.data_byte = value;
    it.is_last   = last;
    send_item(it);
  endtask

  // Stop offering and wait until the whole predicted stream has come out.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (tracker.expected_symbols.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Change the break length with the block idle.
  task automatic write_break(input logic [4:0] bits);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= bits;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.break_setting = bits;
    settings_used++;
  endtask

  // A full frame with random identifier and payload; optionally left without its last byte.
  task automatic send_frame(input bit complete);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
    if (complete && n == 0) begin
      send_fields(FUNC_START, 6'($urandom_range(63)), 8'($urandom_range(255)), 1'b1);
    end else begin
      send_fields(FUNC_START, 6'($urandom_range(63)), 8'($urandom_range(255)), 1'b0);
      for (int i = 0; i < n; i++) begin
        send_fields(FUNC_DATA, 6'($urandom_range(63)), 8'($urandom_range(255)),
                    complete && (i == n - 1));
      end
    end
  endtask

  // Mostly well-formed frames and headers, with broken frames and noise mixed in.
  task automatic random_traffic(input int count);
    int goal;
    int pick;
    goal = tracker.live_items + count;
    while (tracker.live_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send_frame(1'b1);
      end else if (pick < 78) begin
        send_fields(FUNC_HEADER, 6'($urandom_range(63)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
      end else if (pick < 87) begin
        send_frame(1'b0);
      end else if (pick < 94) begin
        send_fields(FUNC_DATA, 6'($urandom_range(63)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
      end else begin
        send_fields(FUNC_UNUSED, 6'($urandom_range(63)), 8'($urandom_range(255)),
                    1'($urandom_range(1)));
      end
    end
  endtask

  // Hard limit on the run.
  initial begin
    #(12 * RUN_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Main sequence.
  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed part at the reset break length.
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_fields(FUNC_START, 6'h00, 8'h00, 1'b1);
    send_fields(FUNC_START, 6'h3F, 8'hFF, 1'b0);
    send_fields(FUNC_DATA, 6'h00, 8'h00, 1'b0);
    send_fields(FUNC_DATA, 6'h3F, 8'hFF, 1'b0);
    send_fields(FUNC_DATA, 6'h2A, 8'hFF, 1'b1);
    send_fields(FUNC_DATA, 6'h15, 8'hAA, 1'b1);
    send_fields(FUNC_DATA, 6'h15, 8'h55, 1'b0);
    send_fields(FUNC_UNUSED, 6'h3F, 8'hFF, 1'b1);
    send_fields(FUNC_HEADER, 6'h3C, 8'h00, 1'b0);
    send_fields(FUNC_HEADER, 6'h3F, 8'hFF, 1'b1);
    // A header abandons an open frame without its checksum.
    send_fields(FUNC_START, 6'h15, 8'h00, 1'b0);
    send_fields(FUNC_DATA, 6'h00, 8'h80, 1'b0);
    send_fields(FUNC_HEADER, 6'h2A, 8'h00, 1'b0);
    // A new start abandons an open frame as well.
    send_fields(FUNC_START, 6'h01, 8'h00, 1'b0);
    send_fields(FUNC_DATA, 6'h00, 8'h7F, 1'b0);
    send_fields(FUNC_UNUSED, 6'h00, 8'h00, 1'b0);
    send_fields(FUNC_START, 6'h3E, 8'h00, 1'b0);
    send_fields(FUNC_DATA, 6'h3F, 8'h01, 1'b1);
    send_fields(FUNC_DATA, 6'h00, 8'h01, 1'b0);

    // A break setting below the minimum.
    write_break(5'd0);
    send_fields(FUNC_HEADER, 6'h12, 8'h00, 1'b0);
    send_fields(FUNC_START, 6'h23, 8'h00, 1'b0);
    send_fields(FUNC_DATA, 6'h00, 8'hFE, 1'b1);

    // Random phase one: sender idles lightly, receiver heavily.
    write_break(5'd31);
    tx_idle_pct = 38;
    rx_idle_pct = 63;
    random_traffic(60);

    // Random phase two: roles swapped.
    write_break(5'd12);
    tx_idle_pct = 63;
    rx_idle_pct = 38;
    random_traffic(60);

    // Random phase three: no idling, with a long output hold-off while items keep coming.
    write_break(5'($urandom_range(14, 30)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_token <= hold_token + 1;
    random_traffic(30);
    wait_drain();
    random_traffic(30);

    // Back to the minimum length for a last frame and header.
    write_break(5'd13);
    send_fields(FUNC_HEADER, 6'h07, 8'h00, 1'b1);
    send_fields(FUNC_START, 6'h30, 8'h00, 1'b1);

    wait_drain();
    repeat (DRAIN_GAP) @(posedge clk);

    $display("Covered %0d frame items and %0d ignored ones, %0d results, %0d closing bytes,",
             tracker.live_items, tracker.ignored_items, tracker.symbols_seen,
             tracker.frames_closed);
    $display("under %0d break settings after reset, with %0d mismatches.",
             settings_used, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
